@@ hdl/sgd_pkg.sv @@
// ----------------------------------------------------------------------------
// sgd_pkg
// Shared constants and types for the Sobel gradient and direction unit.
// ----------------------------------------------------------------------------
package sgd_pkg;

    localparam int MaxWidth  = 1024;
    localparam int PixBits   = 16;
    localparam int CoefBits  = 4;
    localparam int ColBits   = 10;
    localparam int RowBits   = 12;
    localparam int GradBits  = 24;
    localparam int SumBits   = 26;
    localparam int MagBits   = 23;
    localparam int SqBits    = 52;
    localparam int RootBits  = 26;

    localparam logic [17:0] Tan22Q16 = 18'd27146;
    localparam logic [17:0] Tan67Q16 = 18'd158218;

    // register indexes
    localparam logic [1:0] RegWidth   = 2'd0;
    localparam logic [1:0] RegHeight  = 2'd1;
    localparam logic [1:0] RegKernelX = 2'd2;
    localparam logic [1:0] RegKernelY = 2'd3;

    // direction codes
    localparam logic [1:0] Dir0   = 2'd0;
    localparam logic [1:0] Dir45  = 2'd1;
    localparam logic [1:0] Dir90  = 2'd2;
    localparam logic [1:0] Dir135 = 2'd3;

    // job handed from the window stage to the square root unit
    typedef struct packed {
        logic signed [SumBits-1:0] gx;
        logic signed [SumBits-1:0] gy;
        logic                      last;
    } grad_t;

endpackage

@@ hdl/sgd_sqrt.sv @@
// ----------------------------------------------------------------------------
// sgd_sqrt
// Multi-cycle gradient back end: squares, root one result bit a step, direction.
// ----------------------------------------------------------------------------
module sgd_sqrt (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  sgd_pkg::grad_t                       in_job,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [sgd_pkg::GradBits-1:0]  grad_x,
    output logic signed [sgd_pkg::GradBits-1:0]  grad_y,
    output logic        [sgd_pkg::MagBits-1:0]   magnitude,
    output logic        [1:0]                    direction,
    output logic                                 last_of_frame
);

    typedef enum logic [2:0] {S_IDLE, S_SQ, S_SUM, S_ROOT, S_DIR} state_t;

    localparam int SB = sgd_pkg::SqBits;
    localparam int RB = sgd_pkg::RootBits;

    state_t                       state_reg;
    sgd_pkg::grad_t               job_reg;
    logic [sgd_pkg::SumBits-1:0]  ax_reg, ay_reg;
    logic [SB-1:0]                sqx_reg, sqy_reg;
    logic [SB:0]                  rem_reg;
    logic [SB:0]                  res_reg;
    logic [4:0]                   step_reg;
    logic [SB+17:0]               lhs_reg, t22_reg, t67_reg;

    logic [SB:0]     trial;
    logic [SB+17:0]  lhs_w;
    logic [SB:0]     bitv;
    logic            out_load;

    // current trial bit, two places per step from the top
    assign bitv  = (SB+1)'(1) << (2 * (RB - 1 - step_reg));
    assign trial = res_reg + bitv;
    assign lhs_w = (SB+18)'(ay_reg) << 16;

    assign in_ready = (state_reg == S_IDLE);

    // result register is free or empties this cycle
    assign out_load = (state_reg == S_DIR) && (!out_valid || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid <= 1'b0;
        end
        else
        begin
            // output register: load a new result or drop the one transferred
            if (out_load)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        job_reg   <= in_job;
                        ax_reg    <= in_job.gx[sgd_pkg::SumBits-1] ?
                                     -in_job.gx : in_job.gx;
                        ay_reg    <= in_job.gy[sgd_pkg::SumBits-1] ?
                                     -in_job.gy : in_job.gy;
                        state_reg <= S_SQ;
                    end
                end
                // one 26x26 square each, registered
                S_SQ:
                begin
                    sqx_reg   <= SB'(ax_reg) * SB'(ax_reg);
                    sqy_reg   <= SB'(ay_reg) * SB'(ay_reg);
                    t22_reg   <= (SB+18)'(ax_reg) * (SB+18)'(sgd_pkg::Tan22Q16);
                    state_reg <= S_SUM;
                end
                S_SUM:
                begin
                    rem_reg   <= (SB+1)'(sqx_reg) + (SB+1)'(sqy_reg);
                    res_reg   <= '0;
                    step_reg  <= '0;
                    t67_reg   <= (SB+18)'(ax_reg) * (SB+18)'(sgd_pkg::Tan67Q16);
                    lhs_reg   <= lhs_w;
                    state_reg <= S_ROOT;
                end
                // restoring root, one result bit per cycle
                S_ROOT:
                begin
                    if (rem_reg >= trial)
                    begin
                        rem_reg <= rem_reg - trial;
                        res_reg <= (res_reg >> 1) + bitv;
                    end
                    else
                    begin
                        res_reg <= res_reg >> 1;
                    end
                    step_reg <= step_reg + 5'd1;
                    if (step_reg == 5'(RB - 1))
                    begin
                        state_reg <= S_DIR;
                    end
                end
                S_DIR:
                begin
                    if (out_load)
                    begin
                        grad_x  <= ($signed(job_reg.gx) > 26'sd8388607) ? 24'h7FFFFF :
                                   ($signed(job_reg.gx) < -26'sd8388608) ? 24'h800000 :
                                   job_reg.gx[sgd_pkg::GradBits-1:0];
                        grad_y  <= ($signed(job_reg.gy) > 26'sd8388607) ? 24'h7FFFFF :
                                   ($signed(job_reg.gy) < -26'sd8388608) ? 24'h800000 :
                                   job_reg.gy[sgd_pkg::GradBits-1:0];
                        magnitude <= (|res_reg[SB:sgd_pkg::MagBits]) ? '1 :
                                     res_reg[sgd_pkg::MagBits-1:0];
                        last_of_frame <= job_reg.last;
                        if (job_reg.gx == '0)
                            direction <= sgd_pkg::Dir90;
                        else if (lhs_reg <= t22_reg)
                            direction <= sgd_pkg::Dir0;
                        else if ((job_reg.gx > 0) == (job_reg.gy > 0))
                            direction <= (lhs_reg <= t67_reg) ?
                                         sgd_pkg::Dir45 : sgd_pkg::Dir90;
                        else
                            direction <= (lhs_reg < t67_reg) ?
                                         sgd_pkg::Dir135 : sgd_pkg::Dir90;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hdl/sobel_gradient_direction_unit.sv @@
// ----------------------------------------------------------------------------
// sobel_gradient_direction_unit
// Sobel gradients, magnitude and quantized direction over a pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the in channel (in_valid/in_ready/pixel).
// Each pixel that completes a 3x3 window (row and column both at least two)
// gives one result on the out channel: grad_x, grad_y, magnitude, direction
// and last_of_frame; earlier pixels give none.
// The two previous rows live in a line memory read into a register in the
// READ state, with the write-back of the column done in the CALC state.
// Window results are paced by the square root unit: it retires one root bit
// per cycle and takes a new window only when idle. A pixel passes the READ
// and CALC states, then the root unit's SQ, SUM, ROOT and DIR states.
// Reset puts counters and window at zero and registers to their defaults;
// the line memory is not cleared. When the receiver stalls, the result
// holds in the output register, one more result is computed and held, one
// more window waits for the root unit, and then the unit stops taking pixels.
// The user writes registers over the APB port only while idle; not enforced.
// ----------------------------------------------------------------------------
module sobel_gradient_direction_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [4:0]                          paddr,
    input  logic [63:0]                         pwdata,
    output logic [63:0]                         prdata,
    output logic                                pready,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [sgd_pkg::PixBits-1:0]         pixel,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [sgd_pkg::GradBits-1:0] grad_x,
    output logic signed [sgd_pkg::GradBits-1:0] grad_y,
    output logic [sgd_pkg::MagBits-1:0]         magnitude,
    output logic [1:0]                          direction,
    output logic                                last_of_frame
);

    typedef enum logic [1:0] {P_IDLE, P_READ, P_CALC, P_WAIT} state_t;

    localparam int PB = sgd_pkg::PixBits;
    localparam int CB = sgd_pkg::CoefBits;

    logic [10:0] width_reg;
    logic [12:0] height_reg;
    logic [35:0] kx_reg, ky_reg;
    logic [1:0]  reg_idx;

    // configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[4:3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 11'd640;
            height_reg <= 13'd480;
            kx_reg     <= 36'd4548780303;
            ky_reg     <= 36'd4848619503;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                sgd_pkg::RegWidth:   width_reg  <= pwdata[10:0];
                sgd_pkg::RegHeight:  height_reg <= pwdata[12:0];
                sgd_pkg::RegKernelX: kx_reg     <= pwdata[35:0];
                sgd_pkg::RegKernelY: ky_reg     <= pwdata[35:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            sgd_pkg::RegWidth:   prdata = {53'd0, width_reg};
            sgd_pkg::RegHeight:  prdata = {51'd0, height_reg};
            sgd_pkg::RegKernelX: prdata = {28'd0, kx_reg};
            sgd_pkg::RegKernelY: prdata = {28'd0, ky_reg};
            default:             prdata = '0;
        endcase
    end

    // effective frame size, saturated
    logic [10:0] w_eff;
    logic [12:0] h_eff;
    assign w_eff = (width_reg < 11'd3) ? 11'd3 :
                   (width_reg > 11'(sgd_pkg::MaxWidth)) ? 11'(sgd_pkg::MaxWidth) : width_reg;
    assign h_eff = (height_reg < 13'd3) ? 13'd3 :
                   (height_reg > 13'd4096) ? 13'd4096 : height_reg;

    // line memory: both rows of one column in one word
    logic [2*PB-1:0] line_mem [sgd_pkg::MaxWidth];
    logic [2*PB-1:0] rd_data_reg;
    logic            mem_we;
    logic [2*PB-1:0] mem_wd;

    state_t                  state_reg;
    logic [sgd_pkg::ColBits-1:0] col_reg;
    logic [sgd_pkg::RowBits-1:0] row_reg;
    logic [PB-1:0]           pix_reg;
    logic [PB-1:0]           win_reg [6];
    sgd_pkg::grad_t          job;
    logic                    job_valid, job_ready;

    // read once per pixel, held while the job waits
    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[col_reg] <= mem_wd;
        if (state_reg == P_READ)
            rd_data_reg <= line_mem[col_reg];
    end

    // window columns: [2] is new pixel
    logic [PB-1:0] c0, c1, c2;
    assign c0 = rd_data_reg[PB-1:0];
    assign c1 = rd_data_reg[2*PB-1:PB];
    assign c2 = pix_reg;
    assign mem_we = (state_reg == P_CALC);
    assign mem_wd = {c2, c1};

    logic [PB-1:0] wpix [9];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            wpix[i*3+0] = win_reg[i];
            wpix[i*3+1] = win_reg[3+i];
        end
        wpix[2] = c0;
        wpix[5] = c1;
        wpix[8] = c2;
    end

    // nine-tap correlation with both kernels
    logic signed [sgd_pkg::SumBits-1:0] gx_sum, gy_sum;
    always_comb
    begin
        gx_sum = '0;
        gy_sum = '0;
        for (int k = 0; k < 9; k++)
        begin
            gx_sum = gx_sum + sgd_pkg::SumBits'($signed(kx_reg[CB*k +: CB]) *
                     $signed({1'b0, wpix[k]}));
            gy_sum = gy_sum + sgd_pkg::SumBits'($signed(ky_reg[CB*k +: CB]) *
                     $signed({1'b0, wpix[k]}));
        end
    end

    logic col_wrap, row_wrap, have_win;
    assign col_wrap = ({1'b0, col_reg} + 11'd1) >= w_eff;
    assign row_wrap = ({1'b0, row_reg} + 13'd1) >= h_eff;
    assign have_win = (row_reg >= 12'd2) && (col_reg >= 10'd2);

    assign in_ready  = (state_reg == P_IDLE);
    assign job.gx    = gx_sum;
    assign job.gy    = gy_sum;
    assign job.last  = col_wrap && row_wrap;
    assign job_valid = (state_reg == P_CALC || state_reg == P_WAIT) && have_win;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else
        begin
            case (state_reg)
                P_IDLE:
                begin
                    if (in_valid)
                    begin
                        pix_reg   <= pixel;
                        state_reg <= P_READ;
                    end
                end
                P_READ:
                begin
                    state_reg <= P_CALC;
                end
                P_CALC, P_WAIT:
                begin
                    if (!have_win || job_ready)
                    begin
                        win_reg[0] <= win_reg[3];
                        win_reg[1] <= win_reg[4];
                        win_reg[2] <= win_reg[5];
                        win_reg[3] <= c0;
                        win_reg[4] <= c1;
                        win_reg[5] <= c2;
                        if (col_wrap)
                        begin
                            col_reg <= '0;
                            row_reg <= row_wrap ? '0 : row_reg + 12'd1;
                        end
                        else
                        begin
                            col_reg <= col_reg + 10'd1;
                        end
                        state_reg <= P_IDLE;
                    end
                    else
                    begin
                        state_reg <= P_WAIT;
                    end
                end
                default:
                begin
                    state_reg <= P_IDLE;
                end
            endcase
        end
    end

    sgd_sqrt u_sqrt (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (job_valid),
        .in_ready      (job_ready),
        .in_job        (job),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .grad_x        (grad_x),
        .grad_y        (grad_y),
        .magnitude     (magnitude),
        .direction     (direction),
        .last_of_frame (last_of_frame)
    );

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Streams raster frames into the Sobel gradient and direction unit.
// Each pixel transfer runs through a local window model. Every result transfer
// is compared field by field with the oldest expected result. Image size and
// both kernels are set over the APB port between frames. The run covers
// directed bin-edge frames, random frames under three idle mixes, and
// part of a frame at a saturated height.
// ----------------------------------------------------------------------------
module testbench;

    localparam int ClkPeriod = 12;
    localparam int CycleLimit = 3000000;
    localparam int SettleCycles = 45;
    localparam int StallCycles = 400;
    localparam int PhaseItems = 420;
    localparam int TallItems = 120;

    typedef struct {
        logic signed [sgd_pkg::GradBits-1:0] gx;
        logic signed [sgd_pkg::GradBits-1:0] gy;
        logic [sgd_pkg::MagBits-1:0]         mag;
        logic [1:0]                          dir;
        logic                                last;
    } sobel_result_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [4:0] paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic pready;
    logic in_valid;
    logic in_ready;
    logic [sgd_pkg::PixBits-1:0] pixel;
    logic out_valid;
    logic out_ready;
    logic signed [sgd_pkg::GradBits-1:0] grad_x;
    logic signed [sgd_pkg::GradBits-1:0] grad_y;
    logic [sgd_pkg::MagBits-1:0] magnitude;
    logic [1:0] direction;
    logic last_of_frame;

    // model copy of registers and window state
    logic [10:0] cfg_width;
    logic [12:0] cfg_height;
    logic [35:0] cfg_kx;
    logic [35:0] cfg_ky;
    logic [sgd_pkg::PixBits-1:0] line_mem [2][sgd_pkg::MaxWidth] = '{default: '0};
    logic [sgd_pkg::PixBits-1:0] win [6] = '{default: '0};
    int unsigned col_pos = 0;
    int unsigned row_pos = 0;

    logic [sgd_pkg::PixBits-1:0] pixel_queue[$];
    sobel_result_t result_queue[$];
    int unsigned send_idle;
    int unsigned recv_idle;
    logic rx_block;
    logic start_stall;
    int unsigned in_xfers = 0;
    int unsigned in_taken = 0;
    int unsigned cycles = 0;
    int unsigned mismatches = 0;
    int unsigned random_items;

    sobel_gradient_direction_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .pixel(pixel),
        .out_valid(out_valid), .out_ready(out_ready),
        .grad_x(grad_x), .grad_y(grad_y), .magnitude(magnitude),
        .direction(direction), .last_of_frame(last_of_frame)
    );

    initial
    begin
        clk = 1'b0;
        forever #(ClkPeriod / 2) clk = ~clk;
    end

    function automatic int unsigned eff_width();
        int unsigned w;
        w = cfg_width;
        if (w < 3) w = 3;
        if (w > sgd_pkg::MaxWidth) w = sgd_pkg::MaxWidth;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = cfg_height;
        if (h < 3) h = 3;
        if (h > 4096) h = 4096;
        return h;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [1:0] angle_bin(longint gx, longint gy);
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned lhs;
        bit same;
        if (gx == 0) return sgd_pkg::Dir90;
        ax = (gx < 0) ? -gx : gx;
        ay = (gy < 0) ? -gy : gy;
        lhs = ay << 16;
        if (lhs <= ax * sgd_pkg::Tan22Q16) return sgd_pkg::Dir0;
        same = ((gx > 0) == (gy > 0));
        if (same)
            return (lhs <= ax * sgd_pkg::Tan67Q16) ? sgd_pkg::Dir45 : sgd_pkg::Dir90;
        return (lhs < ax * sgd_pkg::Tan67Q16) ? sgd_pkg::Dir135 : sgd_pkg::Dir90;
    endfunction

    function automatic logic signed [sgd_pkg::GradBits-1:0] clamp_grad(longint g);
        if (g > 8388607) g = 8388607;
        if (g < -8388608) g = -8388608;
        return g[sgd_pkg::GradBits-1:0];
    endfunction

    // advance the window model by one pixel, queue a result when a window completes
    function automatic void sobel_predict(logic [sgd_pkg::PixBits-1:0] p);
        int unsigned w;
        int unsigned h;
        int unsigned ci;
        logic [sgd_pkg::PixBits-1:0] col [3];
        longint gx;
        longint gy;
        longint px;
        longint unsigned mag;
        bit last;
        sobel_result_t res;
        w = eff_width();
        h = eff_height();
        ci = col_pos % sgd_pkg::MaxWidth;
        col[0] = line_mem[0][ci];
        col[1] = line_mem[1][ci];
        col[2] = p;
        last = (col_pos + 1 >= w) && (row_pos + 1 >= h);
        if (row_pos >= 2 && col_pos >= 2)
        begin
            gx = 0;
            gy = 0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    px = (j < 2) ? longint'(win[j * 3 + i]) : longint'(col[i]);
                    gx += longint'($signed(cfg_kx[4 * (i * 3 + j) +: 4])) * px;
                    gy += longint'($signed(cfg_ky[4 * (i * 3 + j) +: 4])) * px;
                end
            end
            mag = floor_sqrt(longint'(gx * gx) + longint'(gy * gy));
            if (mag > 8388607) mag = 8388607;
            res.gx = clamp_grad(gx);
            res.gy = clamp_grad(gy);
            res.mag = mag[sgd_pkg::MagBits-1:0];
            res.dir = angle_bin(gx, gy);
            res.last = last;
            result_queue.push_back(res);
        end
        line_mem[0][ci] = col[1];
        line_mem[1][ci] = col[2];
        for (int k = 0; k < 3; k++)
        begin
            win[k] = win[k + 3];
            win[k + 3] = col[k];
        end
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
    endfunction

    // cycle count, pixel transfers and result checking
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("status: fail");
            $finish;
        end
        else if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                sobel_predict(pixel);
                in_xfers++;
            end
            if (out_valid && out_ready)
            begin
                if (result_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer at cycle %0d", cycles);
                end
                else
                begin
                    sobel_result_t e;
                    e = result_queue.pop_front();
                    if (e.gx !== grad_x || e.gy !== grad_y || e.mag !== magnitude
                        || e.dir !== direction || e.last !== last_of_frame)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch cycle %0d: exp gx %0d gy %0d mag %0d dir %0d last %0d",
                                cycles, e.gx, e.gy, e.mag, e.dir, e.last);
                            $display("    got gx %0d gy %0d mag %0d dir %0d last %0d",
                                grad_x, grad_y, magnitude, direction, last_of_frame);
                        end
                    end
                end
            end
        end
    end

    // pixel driver and result ready
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            pixel <= '0;
            out_ready <= 1'b0;
        end
        else
        begin
            if (!in_valid || in_xfers != in_taken)
            begin
                if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle)
                begin
                    in_valid <= 1'b1;
                    pixel <= pixel_queue.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
            out_ready <= rx_block ? 1'b0 : ($urandom_range(99) >= recv_idle);
        end
        in_taken = in_xfers;
    end

    // long receiver hold-off, counted here
    initial
    begin
        rx_block = 1'b0;
        wait (start_stall);
        @(negedge clk);
        rx_block <= 1'b1;
        repeat (StallCycles) @(negedge clk);
        rx_block <= 1'b0;
    end

    task automatic apb_write(logic [1:0] idx, logic [63:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            sgd_pkg::RegWidth:   cfg_width = val[10:0];
            sgd_pkg::RegHeight:  cfg_height = val[12:0];
            sgd_pkg::RegKernelX: cfg_kx = val[35:0];
            sgd_pkg::RegKernelY: cfg_ky = val[35:0];
            default: ;
        endcase
    endtask

    task automatic set_frame(logic [10:0] w, logic [12:0] h,
                             logic [35:0] kx, logic [35:0] ky);
        apb_write(sgd_pkg::RegWidth, {53'd0, w});
        apb_write(sgd_pkg::RegHeight, {51'd0, h});
        apb_write(sgd_pkg::RegKernelX, {28'd0, kx});
        apb_write(sgd_pkg::RegKernelY, {28'd0, ky});
    endtask

    // hold the sender until every expected result is back, then let the pipe settle
    task automatic drain();
        @(negedge clk);
        while (pixel_queue.size() > 0 || in_valid || result_queue.size() > 0)
            @(negedge clk);
        repeat (SettleCycles) @(negedge clk);
    endtask

    // 3x3 frame with only the center row set: p3, p4 (x tap) and p5
    task automatic push_cross(logic [15:0] left, logic [15:0] mid, logic [15:0] right);
        for (int i = 0; i < 9; i++)
            pixel_queue.push_back(i == 3 ? left : i == 4 ? mid : i == 5 ? right : 16'd0);
    endtask

    function automatic logic [35:0] pick_kernel(logic [35:0] dflt);
        case ($urandom_range(5))
            0: return dflt;
            1: return 36'h888888888;
            2: return 36'h777777777;
            default: return 36'({$urandom, $urandom});
        endcase
    endfunction

    task automatic push_frame();
        int unsigned n;
        int unsigned mode;
        logic [15:0] flat;
        n = eff_width() * eff_height();
        mode = $urandom_range(5);
        flat = 16'($urandom);
        for (int i = 0; i < n; i++)
        begin
            case (mode)
                0: pixel_queue.push_back(flat);
                1: pixel_queue.push_back($urandom_range(1) ? 16'hFFFF : 16'h0000);
                default:
                    case ($urandom_range(7))
                        0: pixel_queue.push_back(16'h0000);
                        1: pixel_queue.push_back(16'hFFFF);
                        default: pixel_queue.push_back(16'($urandom));
                    endcase
            endcase
        end
        random_items += n;
    endtask

    task automatic push_partial(int unsigned n);
        for (int i = 0; i < n; i++)
            pixel_queue.push_back(16'($urandom));
    endtask

    task automatic random_phase(int unsigned goal, bit do_stall);
        random_items = 0;
        while (random_items < goal)
        begin
            set_frame(11'($urandom_range(1, 9)), 13'($urandom_range(1, 7)),
                pick_kernel(36'h10F1E2F01), pick_kernel(36'h120F00EEF));
            for (int f = 0; f < 3; f++)
                push_frame();
            if (do_stall && !start_stall)
                start_stall = 1'b1;
            drain();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start_stall = 1'b0;
        send_idle = 0;
        recv_idle = 0;
        cfg_width = 11'd640;
        cfg_height = 13'd480;
        cfg_kx = 36'd4548780303;
        cfg_ky = 36'd4848619503;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: bin edges and zero gradients, gx = p4, gy = p3 + p5
        set_frame(11'd3, 13'd3, 36'h000010000, 36'h000101000);
        push_cross(16'd6786, 16'd32768, 16'd6787);
        push_cross(16'd40000, 16'd32768, 16'd39109);
        push_cross(16'd0, 16'd0, 16'd0);
        drain();
        set_frame(11'd0, 13'd0, 36'h0000F0000, 36'h000101000);
        push_cross(16'd40000, 16'd32768, 16'd39109);
        push_cross(16'd0, 16'hFFFF, 16'd0);
        drain();

        // random frames under the three idle mixes
        send_idle = 35;
        recv_idle = 79;
        random_phase(PhaseItems, 1'b1);
        send_idle = 79;
        recv_idle = 35;
        random_phase(PhaseItems, 1'b0);
        send_idle = 0;
        recv_idle = 0;
        random_phase(PhaseItems, 1'b0);

        // narrowest width with a saturated height, first rows only
        set_frame(11'd1, 13'd8191, 36'h888888888, 36'h777777777);
        push_partial(TallItems);
        drain();

        if (mismatches == 0 && result_queue.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
